[design/fsx_pkg.sv]
// ----------------------------------------------------------------------------
// fsx_pkg
// Shared types and codes for the stack execution unit: stack words, status
// codes and the control word that is broadcast to the row of stack cells.
// ----------------------------------------------------------------------------
package fsx_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int WORD_BITS_DEF   = 32;
  localparam int DICT_WORDS_DEF  = 256;

  // wide enough for a cell index at the largest stack depth
  localparam int IDX_BITS = 10;

  localparam logic [3:0] F_PUSH   = 4'd0;
  localparam logic [3:0] F_EMIT   = 4'd1;
  localparam logic [3:0] F_PICK   = 4'd2;
  localparam logic [3:0] F_ROLL   = 4'd3;
  localparam logic [3:0] F_ADD    = 4'd4;
  localparam logic [3:0] F_MUL    = 4'd5;
  localparam logic [3:0] F_DIV    = 4'd6;
  localparam logic [3:0] F_XOR    = 4'd7;
  localparam logic [3:0] F_AND    = 4'd8;
  localparam logic [3:0] F_RSHIFT = 4'd9;
  localparam logic [3:0] F_LSHIFT = 4'd10;
  localparam logic [3:0] F_ZEROEQ = 4'd11;
  localparam logic [3:0] F_FETCH  = 4'd12;
  localparam logic [3:0] F_STORE  = 4'd13;
  localparam logic [3:0] F_POPOUT = 4'd14;
  localparam logic [3:0] F_NOP    = 4'd15;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    C_HOLD,
    C_PUSH,
    C_POP,
    C_TOP,
    C_LOAD,
    C_SHIFT,
    C_ROLL
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [IDX_BITS-1:0] roll_idx;
  } cell_ctrl_t;

endpackage

[design/fsx_cell.sv]
// ----------------------------------------------------------------------------
// fsx_cell
// One stack entry plus one lane register. Values move to the neighbour cells
// on push and pop; the lane carries a copy of the stack toward the top for
// pick and roll.
// ----------------------------------------------------------------------------
module fsx_cell
  import fsx_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic [WORD_BITS-1:0] above_val,
  input  logic [WORD_BITS-1:0] below_val,
  input  logic [WORD_BITS-1:0] below_lane,
  output logic [WORD_BITS-1:0] val,
  output logic [WORD_BITS-1:0] lane
);

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(INDEX);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      C_PUSH:  val <= above_val;
      C_POP:   val <= below_val;
      C_TOP:   if (INDEX == 0) val <= above_val;
      C_LOAD:  lane <= val;
      C_SHIFT: lane <= below_lane;
      C_ROLL:  if (MY_IDX <= ctrl.roll_idx) val <= above_val;
      default: ;
    endcase
  end

endmodule

[design/fsx_muldiv.sv]
// ----------------------------------------------------------------------------
// fsx_muldiv
// Shared iterative unit, one bit per cycle: shift-add multiply (low word kept)
// and restoring signed divide truncating toward zero.
// ----------------------------------------------------------------------------
module fsx_muldiv
  import fsx_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 is_div,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  output logic                 done,
  output logic [WORD_BITS-1:0] result
);

  localparam int CW = $clog2(WORD_BITS);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic                 div_q;
  logic                 neg;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] sh;
  logic [WORD_BITS-1:0] den;
  logic [WORD_BITS:0]   rem_sh;
  logic [WORD_BITS:0]   diff;
  logic [WORD_BITS-1:0] a_mag;
  logic [WORD_BITS-1:0] b_mag;

  assign a_mag  = a[WORD_BITS-1] ? (~a + 1'b1) : a;
  assign b_mag  = b[WORD_BITS-1] ? (~b + 1'b1) : b;
  assign rem_sh = {acc, sh[WORD_BITS-1]};
  assign diff   = rem_sh - {1'b0, den};
  assign result = div_q ? (neg ? (~sh + 1'b1) : sh) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= CW'(WORD_BITS - 1);
      div_q <= is_div;
      neg   <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
      acc   <= '0;
      sh    <= is_div ? a_mag : b;
      den   <= is_div ? b_mag : a;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (div_q) begin
        if (!diff[WORD_BITS]) begin
          acc <= diff[WORD_BITS-1:0];
          sh  <= {sh[WORD_BITS-2:0], 1'b1};
        end else begin
          acc <= rem_sh[WORD_BITS-1:0];
          sh  <= {sh[WORD_BITS-2:0], 1'b0};
        end
      end else begin
        acc <= {acc[WORD_BITS-2:0], 1'b0} + (sh[WORD_BITS-1] ? den : '0);
        sh  <= {sh[WORD_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

[design/forth_stack_execution_unit.sv]
// Steps per word: push, emit, popout and zero-equals go from execute to done; add
// and the other two-operand words add a write-back; fetch adds a memory read; pick
// and roll add a load, a walk (the lane walks the cell row one entry a cycle) and a
// commit; multiply and divide add a wait (one bit a cycle in the shared multiply/
// divide unit) and a write-back. One word in flight at a time. Reset empties the
// stack, then clears every word of the memory; meanwhile no word is accepted.
// ----------------------------------------------------------------------------
// forth_stack_execution_unit
// Forth-style data stack held in a row of shifting cells, with a word memory
// and an iterative multiply/divide unit, driven by a small sequencer.
// ----------------------------------------------------------------------------
module forth_stack_execution_unit
  import fsx_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF,
  parameter int DICT_WORDS  = DICT_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // func[3:0], push_value[35:4], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // out_value[31:0], out_valid[32], status[35:33],
                                // stack_level[42:36], zero fill
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(DICT_WORDS);
  localparam int SHW = $clog2(WORD_BITS);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_EXEC   = 10'b0000000100,
    S_LOAD   = 10'b0000001000,
    S_WALK   = 10'b0000010000,
    S_COMMIT = 10'b0000100000,
    S_ARITH  = 10'b0001000000,
    S_WB     = 10'b0010000000,
    S_FETCH  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t               state, state_next;
  logic [SPW-1:0]       sp, sp_next;
  logic [SPW-1:0]       walk_cnt, walk_cnt_next;
  logic [IDX_BITS-1:0]  idx_q, idx_next;
  logic [3:0]           func_q;
  logic [WORD_BITS-1:0] pv_q;
  logic [WORD_BITS-1:0] res, res_next;
  logic [WORD_BITS-1:0] t_q, s_q;
  status_t              st_q, st_next;
  logic [31:0]          ov_q, ov_next;
  logic                 ovld_q, ovld_next;
  logic                 addr_ok_q;
  logic [AW-1:0]        clr_addr;

  logic [WORD_BITS-1:0] mem [DICT_WORDS];
  logic [WORD_BITS-1:0] mem_rdata;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  cell_ctrl_t           cctrl;
  logic [WORD_BITS-1:0] cell_in;
  logic [WORD_BITS-1:0] cval  [STACK_DEPTH];
  logic [WORD_BITS-1:0] clane [STACK_DEPTH];

  logic                 md_start, md_div, md_done;
  logic [WORD_BITS-1:0] md_result;

  logic [WORD_BITS-1:0] t_w, s_w;
  logic [63:0]          t_u64, t_s64, pv_s64;
  logic                 t_neg, addr_ok, shamt_big;
  logic [SPW-1:0]       sp_dec;
  logic [WORD_BITS-1:0] simple_res;
  logic                 s_accept;

  assign t_w      = cval[0];
  assign s_w      = cval[1];
  assign t_u64    = 64'(t_w);
  assign t_s64    = 64'(signed'(t_w));
  assign pv_s64   = 64'(signed'(s_tdata[35:4]));
  assign t_neg    = t_w[WORD_BITS-1];
  assign addr_ok  = !t_neg && (t_u64 < 64'(DICT_WORDS));
  assign shamt_big = t_u64 >= 64'(WORD_BITS);
  assign sp_dec   = sp - 1'b1;
  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;

  // stack cell row, top of stack in cell 0
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] above, below, below_l;
    if (g == 0) begin : g_top
      assign above = cell_in;
    end else begin : g_mid
      assign above = cval[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_bot
      assign below   = '0;
      assign below_l = '0;
    end else begin : g_inner
      assign below   = cval[g+1];
      assign below_l = clane[g+1];
    end
    fsx_cell #(
      .WORD_BITS (WORD_BITS),
      .INDEX     (g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cctrl),
      .above_val  (above),
      .below_val  (below),
      .below_lane (below_l),
      .val        (cval[g]),
      .lane       (clane[g])
    );
  end

  fsx_muldiv #(
    .WORD_BITS (WORD_BITS)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .is_div (md_div),
    .a      (s_w),
    .b      (t_w),
    .done   (md_done),
    .result (md_result)
  );

  always_comb begin
    simple_res = '0;
    case (func_q)
      F_ADD:    simple_res = s_w + t_w;
      F_XOR:    simple_res = s_w ^ t_w;
      F_AND:    simple_res = s_w & t_w;
      F_RSHIFT: simple_res = shamt_big ? {WORD_BITS{s_w[WORD_BITS-1]}}
                                       : WORD_BITS'(signed'(s_w) >>> t_w[SHW-1:0]);
      F_LSHIFT: simple_res = shamt_big ? '0 : (s_w << t_w[SHW-1:0]);
      default:  simple_res = '0;
    endcase
  end

  always_comb begin
    state_next    = state;
    sp_next       = sp;
    walk_cnt_next = walk_cnt;
    idx_next      = idx_q;
    res_next      = res;
    st_next       = st_q;
    ov_next       = ov_q;
    ovld_next     = ovld_q;
    cctrl.op       = C_HOLD;
    cctrl.roll_idx = idx_q;
    cell_in       = res;
    md_start      = 1'b0;
    md_div        = (func_q == F_DIV);
    mem_we        = 1'b0;
    mem_waddr     = t_q[AW-1:0];
    mem_wdata     = s_q;
    mem_re        = 1'b0;

    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == AW'(DICT_WORDS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_accept) begin
          st_next    = ST_OK;
          ov_next    = '0;
          ovld_next  = 1'b0;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (func_q)
          F_PUSH: begin
            if (sp >= SPW'(STACK_DEPTH)) begin
              st_next = ST_OVERFLOW;
            end else begin
              cctrl.op = C_PUSH;
              cell_in  = pv_q;
              sp_next  = sp + 1'b1;
            end
          end
          F_EMIT, F_POPOUT: begin
            if (sp == '0) begin
              st_next = ST_UNDERFLOW;
            end else begin
              cctrl.op  = C_POP;
              sp_next   = sp_dec;
              ovld_next = 1'b1;
              ov_next   = (func_q == F_EMIT) ? {24'd0, t_w[7:0]} : t_s64[31:0];
            end
          end
          F_PICK, F_ROLL: begin
            if (sp == '0) begin
              st_next = ST_UNDERFLOW;
            end else begin
              cctrl.op = C_POP;
              sp_next  = sp_dec;
              if (t_neg || (t_u64 >= 64'(sp_dec))) begin
                st_next = ST_RANGE;
              end else begin
                walk_cnt_next = t_w[SPW-1:0];
                idx_next      = IDX_BITS'(t_w[SPW-1:0]);
                state_next    = S_LOAD;
              end
            end
          end
          F_ZEROEQ: begin
            if (sp == '0) begin
              st_next = ST_UNDERFLOW;
            end else begin
              cctrl.op = C_TOP;
              cell_in  = (t_w == '0) ? '1 : '0;
            end
          end
          F_FETCH: begin
            if (sp == '0) begin
              st_next = ST_UNDERFLOW;
            end else if (!addr_ok) begin
              cctrl.op = C_TOP;
              cell_in  = '0;
              st_next  = ST_RANGE;
            end else begin
              mem_re     = 1'b1;
              state_next = S_FETCH;
            end
          end
          F_NOP: ;
          default: begin
            if (sp < SPW'(2)) begin
              st_next = ST_UNDERFLOW;
              if (sp != '0) begin
                // lone operand is still popped
                cctrl.op = C_POP;
                sp_next  = sp_dec;
              end
            end else begin
              cctrl.op = C_POP;
              sp_next  = sp_dec;
              res_next = simple_res;
              if (func_q == F_STORE) begin
                if (!addr_ok) st_next = ST_RANGE;
                state_next = S_WB;
              end else if (func_q == F_MUL) begin
                md_start   = 1'b1;
                state_next = S_ARITH;
              end else if (func_q == F_DIV) begin
                if (t_w == '0) begin
                  st_next    = ST_DIVZERO;
                  res_next   = '0;
                  state_next = S_WB;
                end else begin
                  md_start   = 1'b1;
                  state_next = S_ARITH;
                end
              end else begin
                state_next = S_WB;
              end
            end
          end
        endcase
      end
      S_LOAD: begin
        cctrl.op   = C_LOAD;
        state_next = (walk_cnt == '0) ? S_COMMIT : S_WALK;
      end
      S_WALK: begin
        cctrl.op      = C_SHIFT;
        walk_cnt_next = walk_cnt - 1'b1;
        if (walk_cnt == SPW'(1)) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cell_in    = clane[0];
        state_next = S_DONE;
        if (func_q == F_PICK) begin
          cctrl.op = C_PUSH;
          sp_next  = sp + 1'b1;
        end else begin
          cctrl.op = C_ROLL;
        end
      end
      S_ARITH: begin
        if (md_done) begin
          res_next   = md_result;
          state_next = S_WB;
        end
      end
      S_WB: begin
        state_next = S_DONE;
        if (func_q == F_STORE) begin
          cctrl.op = C_POP;
          sp_next  = sp_dec;
          mem_we   = addr_ok_q;
        end else begin
          cctrl.op = C_TOP;
          cell_in  = res;
        end
      end
      S_FETCH: begin
        cctrl.op   = C_TOP;
        cell_in    = mem_rdata;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      sp       <= '0;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      sp    <= sp_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_cnt <= walk_cnt_next;
    idx_q    <= idx_next;
    res      <= res_next;
    st_q     <= st_next;
    ov_q     <= ov_next;
    ovld_q   <= ovld_next;
    if (s_accept) begin
      func_q <= s_tdata[3:0];
      pv_q   <= pv_s64[WORD_BITS-1:0];
    end
    if (state == S_EXEC) begin
      t_q       <= t_w;
      s_q       <= s_w;
      addr_ok_q <= addr_ok;
    end
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {5'd0, 7'(sp), st_q, ovld_q, ov_q};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[t_w[AW-1:0]];
  end

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_md_done_state: assert property (@(posedge clk) disable iff (rst)
    md_done |-> (state == S_ARITH))
    else $error("multiply/divide finished outside arithmetic wait");

  a_out_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[32]) |-> (m_tdata[35:33] == ST_OK))
    else $error("popped value reported with error status");
`endif

endmodule
